@@ src/assert_macros.svh @@
// Assertion macros for the power history window averager.
// Expects clk and rst in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define PHWA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("phwa assertion failed");

// Check a property on every clock edge, reset included.
`define PHWA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("phwa assertion failed");

`endif

@@ src/phwa_pkg.sv @@
// Shared constants and types for the power history window averager.
// No dependencies; used by the divider and the top level.
package phwa_pkg;

  localparam int HIST_DEPTH_DEF = 256;
  localparam int POWER_W = 21;
  localparam int TIME_W = 32;
  localparam int NUM_W = 38;   // widest dividend: merged running-mean numerator
  localparam int DEN_W = 21;   // widest divisor: magnitude of a 21-bit power
  localparam logic [7:0] SPAN_RESET = 8'd60;
  localparam logic [31:0] SecsPerHour = 32'd3600;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_AVG = 2'd1;
  localparam logic [1:0] MODE_LEFT = 2'd2;

  typedef struct packed {
    logic start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ src/phwa_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module phwa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/phwa_div.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on phwa_pkg for widths and the request/response structs.
module phwa_div (
  input  logic                clk,
  input  logic                rst,
  input  phwa_pkg::div_req_t  req,
  output phwa_pkg::div_rsp_t  rsp
);
  import phwa_pkg::*;

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic             done;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             qbit;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    rem_sh = {rem, quo[NUM_W-1]};
    diff = {1'b0, rem_sh} - {2'b00, den};
    qbit = !diff[DEN_W+1];
    rem_next = qbit ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo <= req.num;
        rem <= '0;
        den <= req.den;
        cnt <= CNT_W'(NUM_W - 1);
      end else if (busy) begin
        rem <= rem_next;
        quo <= {quo[NUM_W-2:0], qbit};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quo = quo;

endmodule

@@ src/power_history_window_averager_unit.sv @@
// Sample: read the newest entry, append a new one or fold into the newest through a divide, then prune old entries.
// Average query: the entries inside the window are walked one per cycle
// through the history RAM read port; the shared divider then forms the mean.
// Time left: up to two window walks and divides plus one more divide.
// One request at a time; reset (synchronous) empties the ring and sets the span to 60 s.
`include "assert_macros.svh"

module power_history_window_averager_unit #(
  parameter int DEPTH = phwa_pkg::HIST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] timestamp_s,
  input  logic signed [20:0] power_mw,
  input  logic        sample_valid,
  input  logic signed [16:0] window_s,
  input  logic        charging,
  input  logic [19:0] battery_now_mwh,
  input  logic [19:0] battery_full_mwh,
  input  logic signed [20:0] long_avg_mw,
  input  logic        long_avg_valid,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_ok,
  output logic signed [20:0] average_mw,
  output logic [31:0] seconds_left
);
  import phwa_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = IW + 1;
  localparam int SUM_W = POWER_W + IW + 1;
  localparam int WORD_W = TIME_W + POWER_W;
  localparam logic [CW:0] DEPTH_L = (CW+1)'(DEPTH);
  localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);

  typedef enum logic [14:0] {
    ST_IDLE   = 15'b000000000000001,
    ST_RDNEW  = 15'b000000000000010,
    ST_SAMPLE = 15'b000000000000100,
    ST_MSTART = 15'b000000000001000,
    ST_MDIV   = 15'b000000000010000,
    ST_PADDR  = 15'b000000000100000,
    ST_PEVAL  = 15'b000000001000000,
    ST_QSTART = 15'b000000010000000,
    ST_QREF   = 15'b000000100000000,
    ST_QWALK  = 15'b000001000000000,
    ST_QSTDIV = 15'b000010000000000,
    ST_QDIV   = 15'b000100000000000,
    ST_ADONE  = 15'b001000000000000,
    ST_TCALC  = 15'b010000000000000,
    ST_TDIV   = 15'b100000000000000
  } state_t;

  typedef enum logic [1:0] {
    AV_QUERY,
    AV_CHG5,
    AV_CHG1,
    AV_ALL
  } purpose_t;

  function automatic logic [IW-1:0] slot_of(logic [IW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = {2'b00, base} + {1'b0, off};
    if (s >= DEPTH_L) begin
      s = s - DEPTH_L;
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] idx_inc(logic [IW-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(logic [IW-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  state_t   state;
  purpose_t purp;
  logic            in_out_pending;
  logic [IW-1:0]   head;
  logic [CW-1:0]   count;
  logic [15:0]     merge_cnt;
  logic [7:0]      span;

  logic [31:0]         now_r;
  logic signed [20:0]  pw_r;
  logic signed [16:0]  lim_r;
  logic [19:0]         bnow_r;
  logic [19:0]         bfull_r;
  logic [IW-1:0]       wslot;
  logic signed [37:0]  prod;
  logic signed [33:0]  tref;
  logic [IW-1:0]       ptr;
  logic [CW-1:0]       k;
  logic signed [SUM_W-1:0] sum;
  logic [CW-1:0]       n;
  logic                avg_ok;
  logic signed [20:0]  avg_v;
  logic                div_neg;
  logic                res_ok;
  logic signed [20:0]  res_avg;
  logic [31:0]         res_secs;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic [IW-1:0]       ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;
  logic [31:0]         rd_time;
  logic signed [20:0]  rd_pw;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [IW-1:0]       newest;
  logic                ring_full;
  logic signed [32:0]  age;
  logic [9:0]          span2;
  logic                prune;
  logic signed [33:0]  dt;
  logic                in_win;
  logic signed [37:0]  mnum;
  logic [37:0]         mnum_mag;
  logic [16:0]         jp1;
  logic [SUM_W-1:0]    sum_mag;
  logic [21:0]         qsig;
  logic [20:0]         vneg;
  logic signed [20:0]  room;
  logic [19:0]         energy;
  logic [31:0]         e_prod;
  logic                v_pos;
  logic                v_neg;
  logic                left_div;

  assign rd_time = ram_rdata[WORD_W-1:POWER_W];
  assign rd_pw = $signed(ram_rdata[POWER_W-1:0]);
  assign in_ready = (state == ST_IDLE) && !in_out_pending;

  always_comb begin
    newest = slot_of(head, count - 1'b1);
    ring_full = (count == DEPTH_L[CW-1:0]);
    age = $signed({1'b0, now_r}) - $signed({1'b0, rd_time});
    span2 = {2'b00, span} + 10'd2;
    prune = age > $signed({23'd0, span2});
    dt = tref - $signed({2'b00, rd_time});
    in_win = lim_r[16] || (dt < $signed({{17{lim_r[16]}}, lim_r}));
    mnum = prod + $signed({{17{pw_r[20]}}, pw_r});
    mnum_mag = mnum[37] ? (~mnum + 1'b1) : mnum;
    jp1 = {1'b0, merge_cnt} + 17'd1;
    sum_mag = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
    qsig = div_neg ? (~div_rsp.quo[21:0] + 1'b1) : div_rsp.quo[21:0];
    vneg = ~avg_v + 1'b1;
    room = $signed({1'b0, bfull_r}) - $signed({1'b0, bnow_r});
    v_pos = !avg_v[20] && (avg_v != '0);
    v_neg = avg_v[20];
    left_div = avg_ok && (v_pos || (v_neg && (room > 21'sd0)));
    energy = v_pos ? bnow_r : room[19:0];
    e_prod = 32'(energy) * SecsPerHour;
  end

  // read address: issued in the state before the one that uses the data
  always_comb begin
    ram_raddr = newest;
    unique case (state)
      ST_PADDR: ram_raddr = head;
      ST_PEVAL: ram_raddr = idx_inc(head);
      ST_QREF:  ram_raddr = ptr;
      ST_QWALK: ram_raddr = idx_dec(ptr);
      default:  ram_raddr = newest;
    endcase
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = wslot;
    ram_wdata = {now_r, pw_r};
    if (state == ST_SAMPLE && (count == '0 || rd_time != now_r)) begin
      ram_we = 1'b1;
      ram_waddr = ring_full ? head : slot_of(head, count);
    end else if (state == ST_MDIV && div_rsp.done) begin
      ram_we = 1'b1;
      ram_wdata = {now_r, qsig[20:0]};
    end
  end

  always_comb begin
    div_req.start = 1'b0;
    div_req.num = '0;
    div_req.den = DEN_W'(1);
    unique case (state)
      ST_MSTART: begin
        div_req.start = 1'b1;
        div_req.num = mnum_mag;
        div_req.den = DEN_W'(jp1);
      end
      ST_QSTDIV: begin
        div_req.start = 1'b1;
        div_req.num = NUM_W'(sum_mag);
        div_req.den = DEN_W'(n);
      end
      ST_TCALC: begin
        div_req.start = left_div;
        div_req.num = NUM_W'(e_prod);
        div_req.den = v_pos ? avg_v : vneg;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head <= '0;
      count <= '0;
      merge_cnt <= '0;
      span <= SPAN_RESET;
      out_valid <= 1'b0;
      in_out_pending <= 1'b0;
    end else begin
      if (cfg_we) begin
        span <= cfg_wdata;
      end
      // hand a finished result to the output register once it is free
      if (in_out_pending && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
        result_ok <= res_ok;
        average_mw <= res_avg;
        seconds_left <= res_secs;
        in_out_pending <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            now_r <= timestamp_s;
            pw_r <= power_mw;
            bnow_r <= battery_now_mwh;
            bfull_r <= battery_full_mwh;
            priority if (mode == MODE_SAMPLE) begin
              state <= sample_valid ? ST_RDNEW : ST_PADDR;
            end else if (mode == MODE_AVG) begin
              lim_r <= window_s;
              purp <= AV_QUERY;
              state <= ST_QSTART;
            end else if (mode == MODE_LEFT) begin
              if (charging) begin
                lim_r <= 17'sd5;
                purp <= AV_CHG5;
                state <= ST_QSTART;
              end else if (long_avg_valid && long_avg_mw != '0) begin
                avg_v <= long_avg_mw;
                avg_ok <= 1'b1;
                state <= ST_TCALC;
              end else begin
                lim_r <= -17'sd1;
                purp <= AV_ALL;
                state <= ST_QSTART;
              end
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_RDNEW: state <= ST_SAMPLE;
        ST_SAMPLE: begin
          if (count == '0 || rd_time != now_r) begin
            if (ring_full) begin
              head <= idx_inc(head);
            end else begin
              count <= count + 1'b1;
            end
            merge_cnt <= 16'd1;
            state <= ST_PADDR;
          end else begin
            wslot <= newest;
            prod <= rd_pw * $signed({1'b0, merge_cnt});
            state <= ST_MSTART;
          end
        end
        ST_MSTART: begin
          div_neg <= mnum[37];
          state <= ST_MDIV;
        end
        ST_MDIV: begin
          if (div_rsp.done) begin
            if (merge_cnt != 16'hFFFF) begin
              merge_cnt <= merge_cnt + 1'b1;
            end
            state <= ST_PADDR;
          end
        end
        ST_PADDR: state <= (count == '0) ? ST_IDLE : ST_PEVAL;
        ST_PEVAL: begin
          if (prune) begin
            head <= idx_inc(head);
            count <= count - 1'b1;
            if (count == CW'(1)) begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_QSTART: begin
          if (count == '0) begin
            avg_ok <= 1'b0;
            state <= ST_ADONE;
          end else begin
            ptr <= newest;
            k <= count;
            sum <= '0;
            n <= '0;
            state <= ST_QREF;
          end
        end
        ST_QREF: begin
          tref <= (rd_time == now_r) ? $signed({2'b00, now_r})
                                     : $signed({2'b00, now_r}) - 34'sd1;
          state <= ST_QWALK;
        end
        ST_QWALK: begin
          if (in_win) begin
            sum <= sum + $signed({{(SUM_W-POWER_W){rd_pw[20]}}, rd_pw});
            n <= n + 1'b1;
            if (k == CW'(1)) begin
              state <= ST_QSTDIV;
            end else begin
              k <= k - 1'b1;
              ptr <= idx_dec(ptr);
            end
          end else if (n == '0) begin
            avg_ok <= 1'b0;
            state <= ST_ADONE;
          end else begin
            state <= ST_QSTDIV;
          end
        end
        ST_QSTDIV: begin
          div_neg <= sum[SUM_W-1];
          state <= ST_QDIV;
        end
        ST_QDIV: begin
          if (div_rsp.done) begin
            avg_v <= qsig[20:0];
            avg_ok <= 1'b1;
            state <= ST_ADONE;
          end
        end
        ST_ADONE: begin
          unique case (purp)
            AV_QUERY: begin
              res_ok <= avg_ok;
              res_avg <= avg_ok ? avg_v : '0;
              res_secs <= '0;
              in_out_pending <= 1'b1;
              state <= ST_IDLE;
            end
            AV_CHG5: begin
              if (avg_ok && v_pos) begin
                lim_r <= 17'sd1;
                purp <= AV_CHG1;
                state <= ST_QSTART;
              end else begin
                state <= ST_TCALC;
              end
            end
            default: state <= ST_TCALC;
          endcase
        end
        ST_TCALC: begin
          div_neg <= 1'b0;
          res_avg <= '0;
          res_secs <= '0;
          res_ok <= avg_ok;
          if (left_div) begin
            state <= ST_TDIV;
          end else begin
            in_out_pending <= 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_TDIV: begin
          if (div_rsp.done) begin
            res_secs <= div_rsp.quo[31:0];
            in_out_pending <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  phwa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  phwa_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  `PHWA_ASSERT(a_count_le_depth, count <= DEPTH_L[CW-1:0])
  `PHWA_ASSERT(a_div_start_free, div_req.start |-> !div_rsp.busy)
  `PHWA_ASSERT(a_pending_moves, (in_out_pending && (!out_valid || out_ready)) |=> out_valid)
  `PHWA_ASSERT(a_ready_div_idle, in_ready |-> !div_rsp.busy)

endmodule
